// ===== rtl/rocg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rocg_pkg
// Shared constants and controller/datapath interface types for the
// rectangle occupancy count grid.
// ----------------------------------------------------------------------------
package rocg_pkg;

   // Grid geometry and count width
   localparam int GRID_W     = 64;
   localparam int GRID_H     = 64;
   localparam int COUNT_BITS = 8;
   localparam int CELLS      = GRID_W * GRID_H;
   localparam int CELL_AW    = $clog2(CELLS);
   localparam int XW         = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int YW         = (GRID_H > 1) ? $clog2(GRID_H) : 1;

   // Field widths
   localparam int FUNC_W     = 2;
   localparam int COORD_W    = 16;
   localparam int HALF_W     = 14;
   localparam int BOUND_W    = 12;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;

   // Operation codes; any other code is a query
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_HIGH = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // capture the accepted word
      logic calc1;      // clamp the corners
      logic calc2;      // convert corners to cell ranges
      logic clr_step;   // clear one cell after reset
      logic scan_step;  // read the current cell and advance
      logic rsp_load;   // capture the result word
   } rocg_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;   // clearing the last cell
      logic scan_last;  // reading the last cell of the rectangle
   } rocg_status_type;

endpackage
`default_nettype wire

// ===== rtl/rocg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rocg_ctrl
// Sequencer: clearing pass, item accept, range setup, cell scan and
// result handoff.
// ----------------------------------------------------------------------------
module rocg_ctrl
   import rocg_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output      logic            req_tready,
   output      logic            rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire rocg_status_type status,
   output      rocg_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC1,
      ST_CALC2,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_tvalid;
      cmd.calc1     = (state_ff == ST_CALC1);
      cmd.calc2     = (state_ff == ST_CALC2);
      cmd.clr_step  = (state_ff == ST_CLEAR);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.rsp_load  = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         // post a new result or drop the one just taken
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clr_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_CALC1;
            end
            ST_CALC1: state_ff <= ST_CALC2;
            ST_CALC2: state_ff <= ST_SCAN;
            ST_SCAN: begin
               if (status.scan_last) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not posted from finish");
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clr_last) |=> (state_ff == ST_IDLE))
      else $error("clear pass did not end");
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_last) |=> (state_ff == ST_DRAIN))
      else $error("scan did not stop at last cell");
`endif

endmodule
`default_nettype wire

// ===== rtl/rocg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rocg_dp
// Bounds registers, corner-to-cell range setup, count memory with
// read-modify-write update, and result register.
// ----------------------------------------------------------------------------
module rocg_dp
   import rocg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rocg_cmd_type          cmd,
   output      rocg_status_type       status,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [FUNC_W-1:0]     req_tuser,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [BOUND_W-1:0]    csr_data
);

   localparam logic [CELL_AW-1:0] ROW_STEP = CELL_AW'(GRID_W);
   localparam logic [CELL_AW-1:0] CLR_TOP  = CELL_AW'(CELLS - 1);
   localparam logic [12:0]        X_TOP    = 13'(GRID_W - 1);
   localparam logic [12:0]        Y_TOP    = 13'(GRID_H - 1);

   // Clamp a Q.4 corner to [lo,hi] (lo wins) and shift so lo becomes zero.
   function automatic logic [16:0] clamp_shift(input logic signed [17:0] v,
                                               input logic signed [17:0] lo,
                                               input logic signed [17:0] hi);
      logic signed [17:0] w;
      logic signed [17:0] d;
      w = v;
      if (w > hi) w = hi;
      if (w < lo) w = lo;
      d = w - lo;
      return d[16:0];
   endfunction

   function automatic logic [12:0] sat_idx(input logic [12:0] v,
                                           input logic [12:0] top);
      return (v > top) ? top : v;
   endfunction

   // Bounds registers
   logic [BOUND_W-1:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;

   // Item registers
   logic [FUNC_W-1:0]  func_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff;
   logic [HALF_W-1:0]  hs_ff;

   // Shifted corners and cell ranges
   logic [16:0]   xa_ff, xb_ff, ya_ff, yb_ff;
   logic [XW-1:0] x_lo_ff, x_hi_ff, x_ff;
   logic [YW-1:0] y_lo_ff, y_hi_ff, y_ff;
   logic [XW-1:0] x_lo_in, x_hi_in;
   logic [YW-1:0] y_lo_in, y_hi_in;

   // Count memory and update path
   logic [COUNT_BITS-1:0] mem [CELLS];
   logic [COUNT_BITS-1:0] mem_q_ff;
   logic [CELL_AW-1:0]    rd_addr;
   logic [CELL_AW-1:0]    wb_addr_ff;
   logic                  wb_vld_ff;
   logic [CELL_AW-1:0]    clr_ff;
   logic                  mem_we;
   logic [CELL_AW-1:0]    mem_wa;
   logic [COUNT_BITS-1:0] mem_wd;
   logic [COUNT_BITS-1:0] new_val;
   logic                  is_add, is_rem, is_query, at_lim;
   logic                  sat_ff, free_ff;
   logic                  sat_in, free_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [17:0] x_lo16, x_hi16, y_lo16, y_hi16;
   logic signed [17:0] cx18, cy18, hs18;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= BOUND_W'(0);
         x_high_ff <= BOUND_W'(63);
         y_low_ff  <= BOUND_W'(0);
         y_high_ff <= BOUND_W'(63);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_X_LOW:  x_low_ff  <= csr_data;
            CSR_X_HIGH: x_high_ff <= csr_data;
            CSR_Y_LOW:  y_low_ff  <= csr_data;
            CSR_Y_HIGH: y_high_ff <= csr_data;
         endcase
      end
   end

   assign x_lo16 = {{2{x_low_ff[BOUND_W-1]}}, x_low_ff, 4'b0000};
   assign x_hi16 = {{2{x_high_ff[BOUND_W-1]}}, x_high_ff, 4'b0000};
   assign y_lo16 = {{2{y_low_ff[BOUND_W-1]}}, y_low_ff, 4'b0000};
   assign y_hi16 = {{2{y_high_ff[BOUND_W-1]}}, y_high_ff, 4'b0000};
   assign cx18   = {{2{cx_ff[COORD_W-1]}}, cx_ff};
   assign cy18   = {{2{cy_ff[COORD_W-1]}}, cy_ff};
   assign hs18   = {4'b0000, hs_ff};

   // Floor the low corner, ceil the high corner, hold both inside the grid
   assign x_lo_in = XW'(sat_idx(xa_ff[16:4], X_TOP));
   assign x_hi_in = XW'(sat_idx(13'((xb_ff + 17'd15) >> 4), X_TOP));
   assign y_lo_in = YW'(sat_idx(ya_ff[16:4], Y_TOP));
   assign y_hi_in = YW'(sat_idx(13'((yb_ff + 17'd15) >> 4), Y_TOP));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         cx_ff   <= req_tdata[15:0];
         cy_ff   <= req_tdata[31:16];
         hs_ff   <= req_tdata[45:32];
      end
      if (cmd.calc1) begin
         xa_ff <= clamp_shift(cx18 - hs18, x_lo16, x_hi16);
         xb_ff <= clamp_shift(cx18 + hs18, x_lo16, x_hi16);
         ya_ff <= clamp_shift(cy18 - hs18, y_lo16, y_hi16);
         yb_ff <= clamp_shift(cy18 + hs18, y_lo16, y_hi16);
      end
      if (cmd.calc2) begin
         x_lo_ff <= x_lo_in;
         x_hi_ff <= x_hi_in;
         y_lo_ff <= y_lo_in;
         y_hi_ff <= y_hi_in;
         x_ff    <= x_lo_in;
         y_ff    <= y_lo_in;
      end else if (cmd.scan_step) begin
         if (x_ff == x_hi_ff) begin
            x_ff <= x_lo_ff;
            y_ff <= y_ff + YW'(1);
         end else begin
            x_ff <= x_ff + XW'(1);
         end
      end
   end

   assign status.scan_last = (x_ff == x_hi_ff) && (y_ff == y_hi_ff);
   assign status.clr_last  = (clr_ff == CLR_TOP);

   assign rd_addr = CELL_AW'(y_ff) * ROW_STEP + CELL_AW'(x_ff);

   // Update of the cell read in the previous cycle
   assign is_add   = (func_ff == FUNC_ADD);
   assign is_rem   = (func_ff == FUNC_REMOVE);
   assign is_query = !is_add && !is_rem;

   always_comb begin
      at_lim  = 1'b0;
      new_val = mem_q_ff;
      if (is_add) begin
         at_lim = (mem_q_ff == {COUNT_BITS{1'b1}});
         if (!at_lim) new_val = mem_q_ff + COUNT_BITS'(1);
      end else if (is_rem) begin
         at_lim = (mem_q_ff == '0);
         if (!at_lim) new_val = mem_q_ff - COUNT_BITS'(1);
      end
   end

   assign sat_in  = sat_ff || (wb_vld_ff && at_lim);
   assign free_in = free_ff && !(wb_vld_ff && is_query && (mem_q_ff != '0));

   assign mem_we = cmd.clr_step || (wb_vld_ff && !is_query);
   assign mem_wa = cmd.clr_step ? clr_ff : wb_addr_ff;
   assign mem_wd = cmd.clr_step ? '0 : new_val;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.scan_step) mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_vld_ff <= 1'b0;
         clr_ff    <= '0;
      end else begin
         wb_vld_ff <= cmd.scan_step;
         if (cmd.clr_step) clr_ff <= clr_ff + CELL_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= rd_addr;
      if (cmd.load) begin
         sat_ff  <= 1'b0;
         free_ff <= 1'b1;
      end else begin
         sat_ff  <= sat_in;
         free_ff <= free_in;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {{(RSP_DATA_W-2){1'b0}}, !is_query && sat_ff, is_query && free_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   a_wb_follows_read: assert property (@(posedge clock) disable iff (reset)
      wb_vld_ff |-> $past(cmd.scan_step))
      else $error("write-back without a preceding read");
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.calc2) |-> (x_lo_ff <= x_hi_ff) && (y_lo_ff <= y_hi_ff))
      else $error("cell range inverted");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !wb_vld_ff)
      else $error("cell update during clearing pass");
`endif

endmodule
`default_nettype wire

// ===== rtl/rect_occupancy_count_grid.sv =====
`default_nettype none
// Response: rsp_tvalid rises once the accepted item has passed range setup, a scan of every
//   cell in the clamped rectangle, a drain step and the result register.
// Items: one item at a time; the scan is set by the single read-modify-write port of the
//   count memory (one cell per cycle).
// Reset: synchronous; a clearing pass over all GRID_W*GRID_H cells (4096) zeroes the
//   counts with req_tready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// rect_occupancy_count_grid
// Occupancy count grid updated and queried by clamped squares.
// ----------------------------------------------------------------------------
module rect_occupancy_count_grid
   import rocg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [15:0] center_x, [31:16] center_y, [45:32] half_size, [47:46] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [FUNC_W-1:0]     req_tuser,
   // response stream
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] region_free, [1] count_saturated, [7:2] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // register write channel
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [BOUND_W-1:0]    csr_data
);

   rocg_cmd_type    cmd;
   rocg_status_type status;

   // Bounds registers take a word in any cycle
   assign csr_ready = 1'b1;

   // Sequencer: clear, accept, set up, scan, hand off
   rocg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Bounds, range setup, count memory and result register
   rocg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
`default_nettype wire
